FILE: rtl/rqt_pkg.sv
// Shared types and constants for the retransmit queue table.
// No dependencies.
package rqt_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_SCAN   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADSTART = 2'd3;

  localparam logic CFG_MAX_COPY = 1'b0;
  localparam logic CFG_RESEND   = 1'b1;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [15:0] handle;
    logic [15:0] length;
    logic [4:0]  retries;  // two's complement, negative means dead
  } rqt_entry_t;

endpackage

FILE: rtl/retransmit_queue_table.sv
// Retransmit queue table: compacted, insertion-ordered list of pending requests.
// Append, clear and a bad scan are answered from the idle state; find reads and compares entries
// in turn; remove then pulls each later entry down, and a scan drops dead entries as it goes.
// One request at a time; the next is taken once busy falls.
// Reset: list empty, max_copy_len 65535, resend_limit 8; entry memory uncleared.
// Results appear for one cycle on done_o; the receiver cannot stall.
// Depends on rqt_pkg and rqt_ram.
module retransmit_queue_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [15:0] seq_number_i,
  input  logic [15:0] cmd_code_i,
  input  logic [15:0] buf_handle_i,
  input  logic [15:0] pkt_length_i,
  input  logic [4:0]  start_pos_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] entry_seq_out_o,
  output logic [15:0] entry_cmd_out_o,
  output logic [15:0] entry_handle_out_o,
  output logic [15:0] copy_len_o,
  output logic [3:0]  retries_left_o,
  output logic [4:0]  next_pos_o,
  output logic [4:0]  entry_count_o
);
  import rqt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_SH_RD, S_SH_WR, S_SCAN_RD, S_SCAN_CHK
  } state_e;

  state_e state_q, state_d;

  logic [15:0]     max_copy_q;
  logic [3:0]      resend_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;    // search / scan position
  logic [CntW-1:0] sh_q, sh_d;      // compaction write pointer
  logic [2:0]      cmd_q, cmd_d;
  logic [15:0]     key_q, key_d;

  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] oseq_q, oseq_d, ocmd_q, ocmd_d, ohdl_q, ohdl_d, ocopy_q, ocopy_d;
  logic [3:0]  oret_q, oret_d;
  logic [4:0]  onext_q, onext_d, ocnt_q, ocnt_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  rqt_entry_t       wdata, rdata;
  logic [CntW-1:0]  idx_inc, sh_inc;

  rqt_ram #(.Width($bits(rqt_entry_t)), .Depth(QueueDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign idx_inc = idx_q + 1'b1;
  assign sh_inc  = sh_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    sh_d     = sh_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    done_d   = 1'b0;
    status_d = status_q;
    oseq_d   = oseq_q;
    ocmd_d   = ocmd_q;
    ohdl_d   = ohdl_q;
    ocopy_d  = ocopy_q;
    oret_d   = oret_q;
    onext_d  = onext_q;
    ocnt_d   = ocnt_q;
    we       = 1'b0;
    waddr    = idx_q[AddrW-1:0];
    wdata    = rdata;
    raddr    = idx_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = command_i;
          key_d    = seq_number_i;
          status_d = ST_MISS;
          oseq_d   = '0;
          ocmd_d   = '0;
          ohdl_d   = '0;
          ocopy_d  = '0;
          oret_d   = '0;
          onext_d  = '0;
          ocnt_d   = 5'(count_q);
          unique case (command_i) inside
            CMD_APPEND: begin
              done_d = 1'b1;
              if (count_q == CntW'(QueueDepth)) begin
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = count_q[AddrW-1:0];
                wdata    = '{seq: seq_number_i, cmd: cmd_code_i, handle: buf_handle_i,
                             length: pkt_length_i, retries: {1'b0, resend_q}};
                count_d  = count_q + 1'b1;
                ocnt_d   = 5'(count_q + 1'b1);
                status_d = ST_OK;
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              idx_d = '0;
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = S_FIND_RD;
              end
            end
            CMD_CLEAR: begin
              done_d   = 1'b1;
              status_d = ST_OK;
              count_d  = '0;
            end
            CMD_SCAN: begin
              if (start_pos_i >= 5'(QueueDepth) || max_copy_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_BADSTART;
              end else begin
                idx_d   = CntW'(start_pos_i);
                state_d = S_SCAN_RD;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (rdata.seq == key_q) begin
          status_d = ST_OK;
          oseq_d   = rdata.seq;
          ocmd_d   = rdata.cmd;
          ohdl_d   = rdata.handle;
          if (cmd_q == CMD_REMOVE) begin
            sh_d    = idx_q;
            state_d = S_SH_RD;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (idx_inc == count_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_FIND_RD;
        end
      end
      // close the gap at sh_q by pulling each later entry down one place
      S_SH_RD: begin
        raddr = sh_inc[AddrW-1:0];
        if (sh_inc < count_q) begin
          state_d = S_SH_WR;
        end else begin
          count_d = count_q - 1'b1;
          if (cmd_q == CMD_SCAN) begin
            state_d = S_SCAN_RD;
          end else begin
            ocnt_d  = 5'(count_q - 1'b1);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SH_WR: begin
        we      = 1'b1;
        waddr   = sh_q[AddrW-1:0];
        sh_d    = sh_inc;
        state_d = S_SH_RD;
      end
      S_SCAN_RD: begin
        if (idx_q < count_q) begin
          state_d = S_SCAN_CHK;
        end else begin
          ocnt_d  = 5'(count_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN_CHK: begin
        if (rdata.length == '0 || rdata.retries[4]) begin
          sh_d    = idx_q;
          state_d = S_SH_RD;
        end else begin
          status_d      = ST_OK;
          oseq_d        = rdata.seq;
          ocmd_d        = rdata.cmd;
          ohdl_d        = rdata.handle;
          ocopy_d       = (rdata.length < max_copy_q) ? rdata.length : max_copy_q;
          oret_d        = rdata.retries[3:0];
          onext_d       = (idx_inc < count_q) ? 5'(idx_inc) : 5'(QueueDepth);
          ocnt_d        = 5'(count_q);
          we            = 1'b1;
          wdata.retries = rdata.retries - 1'b1;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      done_q     <= 1'b0;
      max_copy_q <= 16'hFFFF;
      resend_q   <= 4'd8;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_COPY: max_copy_q <= cfg_data_i;
          CFG_RESEND:   resend_q   <= cfg_data_i[3:0];
          default:      ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    sh_q     <= sh_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    status_q <= status_d;
    oseq_q   <= oseq_d;
    ocmd_q   <= ocmd_d;
    ohdl_q   <= ohdl_d;
    ocopy_q  <= ocopy_d;
    oret_q   <= oret_d;
    onext_q  <= onext_d;
    ocnt_q   <= ocnt_d;
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign entry_seq_out_o    = oseq_q;
  assign entry_cmd_out_o    = ocmd_q;
  assign entry_handle_out_o = ohdl_q;
  assign copy_len_o         = ocopy_q;
  assign retries_left_o     = oret_q;
  assign next_pos_o         = onext_q;
  assign entry_count_o      = ocnt_q;

endmodule

FILE: rtl/rqt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rqt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sim/tb_retransmit_queue_table.sv
// Testbench for the retransmit queue table: directed and random requests,
// checked against a behavioural model held in a small scoreboard class.
// Depends on rqt_pkg and the retransmit_queue_table RTL.
module tb_retransmit_queue_table;
  timeunit 1ns;
  timeprecision 1ps;
  import rqt_pkg::*;

  // one result of the table
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] seq, cmd, handle, copy;
    logic [3:0]  retries;
    logic [4:0]  next, count;
  } rqt_resp_t;

  // behavioural copy of the table plus the queue of pending responses
  class rqt_scoreboard;
    logic [15:0] t_seq[QueueDepth], t_cmd[QueueDepth], t_hdl[QueueDepth];
    logic [15:0] t_len[QueueDepth];
    logic signed [4:0] t_ret[QueueDepth];
    int unsigned n_live;
    logic [15:0] max_copy;
    logic [3:0]  limit;
    rqt_resp_t   pending[$];
    int          mismatches;

    function new();
      n_live = 0; max_copy = 16'hFFFF; limit = 4'd8; mismatches = 0;
    endfunction

    function void drop(int unsigned p);
      for (int unsigned i = p; i + 1 < n_live; i++) begin
        t_seq[i] = t_seq[i+1]; t_cmd[i] = t_cmd[i+1]; t_hdl[i] = t_hdl[i+1];
        t_len[i] = t_len[i+1]; t_ret[i] = t_ret[i+1];
      end
      n_live--;
    endfunction

    function void note_request(logic [2:0] op, logic [15:0] sq, logic [15:0] cd,
                               logic [15:0] hd, logic [15:0] ln, logic [4:0] sp);
      rqt_resp_t r;
      int pos;
      int unsigned s;
      r = '{status: ST_MISS, default: '0};
      pos = -1;
      case (op)
        CMD_APPEND: begin
          if (n_live >= QueueDepth) r.status = ST_FULL;
          else begin
            t_seq[n_live] = sq; t_cmd[n_live] = cd; t_hdl[n_live] = hd;
            t_len[n_live] = ln; t_ret[n_live] = {1'b0, limit};
            n_live++; r.status = ST_OK;
          end
        end
        CMD_FIND, CMD_REMOVE: begin
          for (int i = 0; i < n_live; i++)
            if (pos < 0 && t_seq[i] == sq) pos = i;
          if (pos >= 0) begin
            r.status = ST_OK;
            r.seq = t_seq[pos]; r.cmd = t_cmd[pos]; r.handle = t_hdl[pos];
            if (op == CMD_REMOVE) drop(pos);
          end
        end
        CMD_CLEAR: begin
          r.status = ST_OK; r.count = 5'(n_live); n_live = 0;
        end
        CMD_SCAN: begin
          s = sp;
          if (s >= QueueDepth || max_copy == 0) r.status = ST_BADSTART;
          else begin
            while (s < n_live) begin
              if (t_len[s] == 0 || t_ret[s] < 0) begin
                drop(s);
                continue;
              end
              r.status = ST_OK;
              r.seq = t_seq[s]; r.cmd = t_cmd[s]; r.handle = t_hdl[s];
              r.copy = (t_len[s] < max_copy) ? t_len[s] : max_copy;
              r.retries = t_ret[s][3:0];
              t_ret[s] = t_ret[s] - 5'sd1;
              r.next = (s + 1 < n_live) ? 5'(s + 1) : 5'(QueueDepth);
              break;
            end
          end
        end
        default: ;
      endcase
      if (op != CMD_CLEAR) r.count = 5'(n_live);
      pending.push_back(r);
    endfunction

    function void check_response(rqt_resp_t a);
      rqt_resp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", a.status);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp st=%0d sq=%h cd=%h hd=%h cl=%h rt=%0d np=%0d n=%0d",
                   e.status, e.seq, e.cmd, e.handle, e.copy, e.retries, e.next, e.count,
                   " | act st=%0d sq=%h cd=%h hd=%h cl=%h rt=%0d np=%0d n=%0d",
                   a.status, a.seq, a.cmd, a.handle, a.copy, a.retries, a.next, a.count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0, cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic start = 1'b0, busy, done_o;
  logic [2:0] command_i = '0;
  logic [15:0] seq_number_i = '0, cmd_code_i = '0, buf_handle_i = '0, pkt_length_i = '0;
  logic [4:0] start_pos_i = '0;
  logic [1:0] status_o;
  logic [15:0] entry_seq_out_o, entry_cmd_out_o, entry_handle_out_o, copy_len_o;
  logic [3:0] retries_left_o;
  logic [4:0] next_pos_o, entry_count_o;

  rqt_scoreboard sb = new();
  int idle_pct = 0;
  logic [15:0] seq_pool[8];  // small key pool so finds and removes hit often

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  retransmit_queue_table uut (.*);

  // responses are sampled on the edge that ends the strobe cycle
  always @(posedge clk_i)
    if (rst_ni && done_o)
      sb.check_response('{status_o, entry_seq_out_o, entry_cmd_out_o, entry_handle_out_o,
                          copy_len_o, retries_left_o, next_pos_o, entry_count_o});

  // hard stop, far beyond the slowest legal run
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // start stays high between back-to-back requests; it drops only for idle gaps
  task automatic send_request(logic [2:0] op, logic [15:0] sq, logic [15:0] cd,
                              logic [15:0] hd, logic [15:0] ln, logic [4:0] sp);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1; command_i <= op; seq_number_i <= sq; cmd_code_i <= cd;
    buf_handle_i <= hd; pkt_length_i <= ln; start_pos_i <= sp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // accepted at this edge
    sb.note_request(op, sq, cd, hd, ln, sp);
  endtask

  // wait out every pending response, then a margin before touching registers
  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_COPY) sb.max_copy = val;
    else sb.limit = val[3:0];
    @(posedge clk_i);
  endtask

  task automatic random_request();
    int r;
    logic [2:0] op;
    logic [15:0] ln;
    r = $urandom_range(99);
    if (r < 35) op = CMD_APPEND;
    else if (r < 50) op = CMD_FIND;
    else if (r < 65) op = CMD_REMOVE;
    else if (r < 68) op = CMD_CLEAR;
    else if (r < 97) op = CMD_SCAN;
    else op = 3'($urandom_range(7, 5));
    // half short lengths, the rest zero-length or wide values
    case ($urandom_range(3))
      0: ln = 16'd0;
      1: ln = 16'($urandom);
      default: ln = 16'($urandom_range(1, 300));
    endcase
    send_request(op, ($urandom_range(9) == 0) ? 16'($urandom) : seq_pool[$urandom_range(7)],
                 16'($urandom), 16'($urandom), ln,
                 ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(16)));
  endtask

  initial begin
    foreach (seq_pool[i]) seq_pool[i] = 16'($urandom);
    seq_pool[0] = 16'h0000; seq_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-table misses, extremes, fill to full
    send_request(CMD_FIND, 16'h0000, '0, '0, '0, '0);
    send_request(CMD_SCAN, '0, '0, '0, '0, 5'd0);
    send_request(CMD_SCAN, '0, '0, '0, '0, 5'd16);
    send_request(CMD_SCAN, '0, '0, '0, '0, 5'd31);
    send_request(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0);
    send_request(CMD_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    for (int i = 0; i < 15; i++)
      send_request(CMD_APPEND, 16'(i + 1), 16'($urandom), 16'($urandom),
                   16'(i * 100), 5'd0);  // last one hits full
    send_request(CMD_SCAN, '0, '0, '0, '0, 5'd0);   // stops at entry 0, which is live; the zero-length entries stay
    send_request(CMD_FIND, 16'h1234, '0, '0, '0, '0);
    send_request(CMD_REMOVE, 16'd5, '0, '0, '0, '0);
    send_request(3'd7, '0, '0, '0, '0, '0);
    send_request(CMD_CLEAR, '0, '0, '0, '0, '0);
    drain();

    // random phases with differing registers and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MAX_COPY, 16'd1); write_reg(CFG_RESEND, 16'd0); end
        1: begin write_reg(CFG_MAX_COPY, 16'hFFFF); write_reg(CFG_RESEND, 16'd15); end
        2: begin write_reg(CFG_MAX_COPY, 16'd0); write_reg(CFG_RESEND, 16'd1); end
        default: begin
          write_reg(CFG_MAX_COPY, 16'($urandom_range(1, 400)));
          write_reg(CFG_RESEND, 16'($urandom_range(0, 3)));
        end
      endcase
      idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 3) ? 8 : 46;
      repeat (118) random_request();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
